// ===== src/rtm_pkg.sv =====
// rob_timing_model package: codes, widths, reset values and shared structs
// used by the front end, the command queue, the back end and the checker.
// No dependencies.
`default_nettype none

package rtm_pkg;

    localparam int CYC_W       = 64;
    localparam int LAT_W       = 16;
    localparam int LAT_SHORT_W = 10;
    localparam int KIND_W      = 2;
    localparam int CLS_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int STAT_W      = 8;
    localparam int COMMIT_W    = 3;
    localparam int OUT_TDATA_W = 24;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NONMEM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS   = 3'd4;

    localparam logic [LAT_SHORT_W-1:0] NONMEM_LAT_RST = 10'd1;
    localparam logic [LAT_SHORT_W-1:0] L1_LAT_RST     = 10'd4;
    localparam logic [LAT_SHORT_W-1:0] L2_LAT_RST     = 10'd12;
    localparam logic [LAT_SHORT_W-1:0] L3_LAT_RST     = 10'd40;
    localparam logic [LAT_W-1:0]       MISS_LAT_RST   = 16'd200;

    // instruction classes
    localparam logic [CLS_W-1:0] CLS_NONMEM = 3'd0;
    localparam logic [CLS_W-1:0] CLS_WRITE  = 3'd1;
    localparam logic [CLS_W-1:0] CLS_L1     = 3'd2;
    localparam logic [CLS_W-1:0] CLS_L2     = 3'd3;
    localparam logic [CLS_W-1:0] CLS_L3     = 3'd4;
    localparam logic [CLS_W-1:0] CLS_MISS   = 3'd5;

    localparam logic [STAT_W-1:0] MISS_CNT_MAX = 8'hFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_ISSUE = 2'd1,
        KIND_COMPL = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ISSUE,
        B_TICK,
        B_SEARCH,
        B_OUT
    } t_back_state;

    // decoded command from the front end
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              cls_ok;
        logic              miss;
        logic [LAT_W-1:0]  lat;
    } t_cmd;

    // result beat, first member in the highest bits
    typedef struct packed {
        logic                full_res;
        logic [STAT_W-1:0]   outstanding_misses;
        logic [STAT_W-1:0]   occupancy;
        logic                matched;
        logic [COMMIT_W-1:0] committed;
        logic                accepted;
    } t_result;

endpackage

`default_nettype wire

// ===== src/rtm_front.sv =====
// rob_timing_model front end: latency registers, input decode and queue push.
// Depends on rtm_pkg.
`default_nettype none

module rtm_front import rtm_pkg::*; #(
    parameter int ADDR_BITS = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [CLS_W-1:0]      i_op_class,
    input  wire logic [ADDR_BITS-1:0]  i_addr,
    input  wire logic                  i_q_full,
    output logic                       o_ready,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    output logic [ADDR_BITS-1:0]       o_addr
);

    logic [LAT_SHORT_W-1:0] r_nonmem_lat;
    logic [LAT_SHORT_W-1:0] r_l1_lat;
    logic [LAT_SHORT_W-1:0] r_l2_lat;
    logic [LAT_SHORT_W-1:0] r_l3_lat;
    logic [LAT_W-1:0]       r_miss_lat;
    logic [LAT_W-1:0]       lat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonmem_lat <= NONMEM_LAT_RST;
            r_l1_lat     <= L1_LAT_RST;
            r_l2_lat     <= L2_LAT_RST;
            r_l3_lat     <= L3_LAT_RST;
            r_miss_lat   <= MISS_LAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NONMEM: r_nonmem_lat <= i_cfg_data[LAT_SHORT_W-1:0];
                CFG_L1:     r_l1_lat     <= i_cfg_data[LAT_SHORT_W-1:0];
                CFG_L2:     r_l2_lat     <= i_cfg_data[LAT_SHORT_W-1:0];
                CFG_L3:     r_l3_lat     <= i_cfg_data[LAT_SHORT_W-1:0];
                CFG_MISS:   r_miss_lat   <= i_cfg_data[LAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_op_class)
            CLS_NONMEM, CLS_WRITE: lat = LAT_W'(r_nonmem_lat);
            CLS_L1:                lat = LAT_W'(r_l1_lat);
            CLS_L2:                lat = LAT_W'(r_l2_lat);
            CLS_L3:                lat = LAT_W'(r_l3_lat);
            CLS_MISS:              lat = r_miss_lat;
            default:               lat = '0;
        endcase
    end

    // no beat is taken while reset is held
    assign o_ready      = i_rst_n && !i_q_full;
    assign o_push       = i_valid && o_ready;
    assign o_cmd.kind   = i_kind;
    assign o_cmd.cls_ok = (i_op_class <= CLS_MISS);
    assign o_cmd.miss   = (i_op_class == CLS_MISS);
    assign o_cmd.lat    = lat;
    assign o_addr       = i_addr;

endmodule

`default_nettype wire

// ===== src/rtm_queue.sv =====
// rob_timing_model command queue: small register fifo between front and back.
// Depends on rtm_pkg only for the common import convention.
`default_nettype none

module rtm_queue import rtm_pkg::*; #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wptr + 1'b1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/rtm_back.sv =====
// rob_timing_model back end: entry memory, head/tail pointers, counters,
// commit and completion walk, and the result register. Depends on rtm_pkg.
`default_nettype none

module rtm_back import rtm_pkg::*; #(
    parameter int ROB_DEPTH    = 128,
    parameter int RETIRE_WIDTH = 4,
    parameter int ADDR_BITS    = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire t_cmd                 i_q_ctl,
    input  wire logic [ADDR_BITS-1:0] i_q_addr,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_result                   o_result
);

    localparam int PTR_W = $clog2(ROB_DEPTH);
    localparam int CNT_W = $clog2(ROB_DEPTH + 1);
    localparam int RET_W = $clog2(RETIRE_WIDTH + 1);
    // entry layout: {ready cycle, miss address, miss flag}
    localparam int ENT_W = CYC_W + ADDR_BITS + 1;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(ROB_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    logic [ENT_W-1:0]     r_rob_mem [ROB_DEPTH];
    logic [ENT_W-1:0]     r_rd_data;

    t_back_state          r_state,     n_state;
    logic [PTR_W-1:0]     r_head,      n_head;
    logic [PTR_W-1:0]     r_tail,      n_tail;
    logic [CNT_W-1:0]     r_in_flight, n_in_flight;
    logic [STAT_W-1:0]    r_miss_cnt,  n_miss_cnt;
    logic [CYC_W-1:0]     r_cycle,     n_cycle;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out_data,  n_out_data;
    t_cmd                 r_ctl,       n_ctl;
    logic [ADDR_BITS-1:0] r_addr,      n_addr;
    logic [PTR_W-1:0]     r_pos,       n_pos;
    logic [CNT_W-1:0]     r_idx,       n_idx;
    logic [RET_W-1:0]     r_committed, n_committed;
    logic                 r_accepted,  n_accepted;
    logic                 r_matched,   n_matched;

    logic                 mem_we;
    logic [PTR_W-1:0]     mem_wa;
    logic [ENT_W-1:0]     mem_wd;
    logic [PTR_W-1:0]     mem_ra;
    logic [CYC_W-1:0]     ent_ready;
    logic [ADDR_BITS-1:0] ent_addr;
    logic                 ent_miss;

    assign ent_ready = r_rd_data[ENT_W-1 -: CYC_W];
    assign ent_addr  = r_rd_data[ADDR_BITS:1];
    assign ent_miss  = r_rd_data[0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rob_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_rob_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_in_flight <= '0;
            r_miss_cnt  <= '0;
            r_cycle     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_in_flight <= n_in_flight;
            r_miss_cnt  <= n_miss_cnt;
            r_cycle     <= n_cycle;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_ctl       <= n_ctl;
        r_addr      <= n_addr;
        r_pos       <= n_pos;
        r_idx       <= n_idx;
        r_committed <= n_committed;
        r_accepted  <= n_accepted;
        r_matched   <= n_matched;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_in_flight = r_in_flight;
        n_miss_cnt  = r_miss_cnt;
        n_cycle     = r_cycle;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        n_ctl       = r_ctl;
        n_addr      = r_addr;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_committed = r_committed;
        n_accepted  = r_accepted;
        n_matched   = r_matched;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_tail;
        mem_wd      = '0;
        // head entry is fetched while idle so tick and search start on it
        mem_ra      = r_head;

        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop     = 1'b1;
                    n_ctl       = i_q_ctl;
                    n_addr      = i_q_addr;
                    n_pos       = r_head;
                    n_idx       = '0;
                    n_committed = '0;
                    n_accepted  = 1'b0;
                    n_matched   = 1'b0;
                    case (i_q_ctl.kind)
                        KIND_TICK:  n_state = B_TICK;
                        KIND_ISSUE: n_state = B_ISSUE;
                        KIND_COMPL: n_state = B_SEARCH;
                        default:    n_state = B_OUT;
                    endcase
                end
            end

            B_ISSUE: begin
                if (r_in_flight != CNT_W'(ROB_DEPTH) && r_ctl.cls_ok) begin
                    mem_we = 1'b1;
                    mem_wa = r_tail;
                    mem_wd = {CYC_W'(r_cycle + CYC_W'(r_ctl.lat)),
                              r_ctl.miss ? r_addr : {ADDR_BITS{1'b0}},
                              r_ctl.miss};
                    if (r_ctl.miss && r_miss_cnt != MISS_CNT_MAX) begin
                        n_miss_cnt = STAT_W'(r_miss_cnt + 1'b1);
                    end
                    n_tail      = next_slot(r_tail);
                    n_in_flight = CNT_W'(r_in_flight + 1'b1);
                    n_accepted  = 1'b1;
                end
                n_state = B_OUT;
            end

            B_TICK: begin
                // one head entry per cycle, next head fetched as this one retires
                if (r_in_flight != '0 && r_committed != RET_W'(RETIRE_WIDTH)
                        && !(ent_ready > r_cycle)) begin
                    n_head      = next_slot(r_head);
                    mem_ra      = next_slot(r_head);
                    n_in_flight = CNT_W'(r_in_flight - 1'b1);
                    n_committed = RET_W'(r_committed + 1'b1);
                end else begin
                    n_cycle = CYC_W'(r_cycle + 1'b1);
                    n_state = B_OUT;
                end
            end

            B_SEARCH: begin
                mem_ra = r_pos;
                if (r_idx == r_in_flight) begin
                    n_state = B_OUT;
                end else if (ent_miss && ent_addr == r_addr) begin
                    mem_we    = 1'b1;
                    mem_wa    = r_pos;
                    mem_wd    = {{CYC_W{1'b0}}, ent_addr, 1'b0};
                    n_matched = 1'b1;
                    if (r_miss_cnt != '0) begin
                        n_miss_cnt = STAT_W'(r_miss_cnt - 1'b1);
                    end
                    n_state = B_OUT;
                end else begin
                    n_idx  = CNT_W'(r_idx + 1'b1);
                    n_pos  = next_slot(r_pos);
                    mem_ra = next_slot(r_pos);
                end
            end

            B_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid                   = 1'b1;
                    n_out_data.accepted           = r_accepted;
                    n_out_data.committed          = COMMIT_W'(r_committed);
                    n_out_data.matched            = r_matched;
                    n_out_data.occupancy          = STAT_W'(r_in_flight);
                    n_out_data.outstanding_misses = r_miss_cnt;
                    n_out_data.full_res           = (r_in_flight == CNT_W'(ROB_DEPTH));
                    n_state                       = B_IDLE;
                end
            end

            default: n_state = B_IDLE;
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_data;

endmodule

`default_nettype wire

// ===== src/rob_timing_model.sv =====
// rob_timing_model: reorder buffer timing model, top level.
// path of an input beat: the command queue, then the back end's idle state, its issue, tick
// or search state and its output state, which registers the result beat.
// the back end works on one command at a time while the queue holds up to two waiting ones;
// tick and completion walk the entries one a cycle through the single read port of the entry memory.
// reset: synchronous, active low; clears pointers, counters and cycle, reloads default
// latencies, leaves memory as it is.
`default_nettype none

module rob_timing_model import rtm_pkg::*; #(
    parameter int ROB_DEPTH    = 128,
    parameter int RETIRE_WIDTH = 4,
    parameter int ADDR_BITS    = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tuser: kind
    input  wire logic [KIND_W-1:0]     s_axis_tuser,
    // tdata: op_class, address, zero padding
    input  wire logic [((CLS_W+ADDR_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: accepted, committed, matched, occupancy, outstanding_misses, full_res, padding
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int Q_W = $bits(t_cmd) + ADDR_BITS;

    t_cmd                 front_cmd;
    logic [ADDR_BITS-1:0] front_addr;
    logic                 front_push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [Q_W-1:0]       q_data;
    t_cmd                 q_ctl;
    logic [ADDR_BITS-1:0] q_addr;
    t_result              result;

    rtm_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_kind      (s_axis_tuser),
        .i_op_class  (s_axis_tdata[CLS_W-1:0]),
        .i_addr      (s_axis_tdata[CLS_W+ADDR_BITS-1:CLS_W]),
        .i_q_full    (q_full),
        .o_ready     (s_axis_tready),
        .o_push      (front_push),
        .o_cmd       (front_cmd),
        .o_addr      (front_addr)
    );

    rtm_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  ({front_addr, front_cmd}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_ctl  = q_data[$bits(t_cmd)-1:0];
    assign q_addr = q_data[Q_W-1:$bits(t_cmd)];

    rtm_back #(
        .ROB_DEPTH    (ROB_DEPTH),
        .RETIRE_WIDTH (RETIRE_WIDTH),
        .ADDR_BITS    (ADDR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ctl   (q_ctl),
        .i_q_addr  (q_addr),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, result};

endmodule

`default_nettype wire

// ===== src/rtm_checker.sv =====
// rob_timing_model checker: port-level assertions on result beats, and the bind
// that attaches it to the top level. Depends on rtm_pkg and rob_timing_model.
`default_nettype none

module rtm_checker import rtm_pkg::*; #(
    parameter int ROB_DEPTH    = 128,
    parameter int RETIRE_WIDTH = 4
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_result res;

    assign res = m_axis_tdata[$bits(t_result)-1:0];

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // only one kind of step reports per beat
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0({res.accepted, res.committed != '0, res.matched}))
        else $error("result mixes issue, tick and completion fields");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.full_res |-> res.occupancy == STAT_W'(ROB_DEPTH))
        else $error("full flag without full occupancy");

    a_retire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> int'(res.committed) <= RETIRE_WIDTH)
        else $error("tick committed more than the retire width");

endmodule

bind rob_timing_model rtm_checker #(
    .ROB_DEPTH    (ROB_DEPTH),
    .RETIRE_WIDTH (RETIRE_WIDTH)
) u_rtm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/rob_timing_model_tb.sv =====
// rob_timing_model_tb: self-checking bench for the reorder buffer timing model.
// Holds a predictor of the buffer state and checks every result beat field by field.
// Depends on rtm_pkg and rob_timing_model.

module rob_timing_model_tb;
    import rtm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROB_DEPTH   = 128;
    localparam int RETIRE_W    = 4;
    localparam int ADDR_W      = 48;
    localparam int IN_TDATA_W  = ((CLS_W + ADDR_W + 7) / 8) * 8;
    localparam int LONG_HOLD   = 600;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_WAIT   = 140;

    // codes the block must tolerate but the package leaves unnamed
    localparam logic [KIND_W-1:0]    KIND_NONE  = 2'd3;
    localparam logic [CLS_W-1:0]     CLS_BAD_LO = 3'd6;
    localparam logic [CLS_W-1:0]     CLS_BAD_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 3'd5;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CLS_W-1:0]  cls;
        logic [ADDR_W-1:0] addr;
        int                gap;
    } t_rob_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tuser: kind
    logic [KIND_W-1:0]     s_axis_tuser = '0;
    // tdata: op_class, address, zero padding
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: accepted, committed, matched, occupancy, outstanding_misses, full_res, padding
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    rob_timing_model #(
        .ROB_DEPTH   (ROB_DEPTH),
        .RETIRE_WIDTH(RETIRE_W),
        .ADDR_BITS   (ADDR_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predicted buffer state
    logic [CYC_W-1:0]       ready_at [ROB_DEPTH];
    logic [ADDR_W-1:0]      pend_addr[ROB_DEPTH];
    logic                   pend_miss[ROB_DEPTH];
    logic [6:0]             rob_head = '0;
    logic [6:0]             rob_tail = '0;
    int                     rob_count = 0;
    logic [STAT_W-1:0]      miss_cnt = '0;
    logic [CYC_W-1:0]       now_cycle = '0;
    logic [LAT_SHORT_W-1:0] lat_nonmem = NONMEM_LAT_RST;
    logic [LAT_SHORT_W-1:0] lat_l1 = L1_LAT_RST;
    logic [LAT_SHORT_W-1:0] lat_l2 = L2_LAT_RST;
    logic [LAT_SHORT_W-1:0] lat_l3 = L3_LAT_RST;
    logic [LAT_W-1:0]       lat_miss = MISS_LAT_RST;

    t_rob_item   item_q[$];
    t_result     status_q[$];
    t_rob_item   cur_item;
    logic        offering = 1'b0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          hold_req_cnt = 0;
    int          hold_seen = 0;
    int          beats = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    logic [ADDR_W-1:0] miss_pool[8];

    function automatic t_result predict_status(input logic [KIND_W-1:0] kind,
                                               input logic [CLS_W-1:0] cls,
                                               input logic [ADDR_W-1:0] addr);
        t_result          r;
        logic [CYC_W-1:0] lat;
        logic [6:0]       pos;
        logic             found;
        r = '0;
        case (kind)
            KIND_TICK: begin
                while (r.committed < RETIRE_W && rob_count != 0
                       && ready_at[rob_head] <= now_cycle) begin
                    rob_head = rob_head + 7'd1;
                    rob_count--;
                    r.committed = r.committed + 3'd1;
                end
                now_cycle = now_cycle + 64'd1;
            end
            KIND_ISSUE: begin
                if (rob_count < ROB_DEPTH && cls <= CLS_MISS) begin
                    case (cls)
                        CLS_NONMEM, CLS_WRITE: lat = CYC_W'(lat_nonmem);
                        CLS_L1:                lat = CYC_W'(lat_l1);
                        CLS_L2:                lat = CYC_W'(lat_l2);
                        CLS_L3:                lat = CYC_W'(lat_l3);
                        default:               lat = CYC_W'(lat_miss);
                    endcase
                    ready_at[rob_tail] = now_cycle + lat;
                    if (cls == CLS_MISS) begin
                        pend_addr[rob_tail] = addr;
                        pend_miss[rob_tail] = 1'b1;
                        if (miss_cnt != MISS_CNT_MAX) miss_cnt = miss_cnt + 8'd1;
                    end else begin
                        pend_addr[rob_tail] = '0;
                        pend_miss[rob_tail] = 1'b0;
                    end
                    rob_tail = rob_tail + 7'd1;
                    rob_count++;
                    r.accepted = 1'b1;
                end
            end
            KIND_COMPL: begin
                pos = rob_head;
                found = 1'b0;
                for (int n = 0; n < rob_count; n++) begin
                    // only live misses take part, stale addresses of other entries never match
                    if (!found && pend_miss[pos] && pend_addr[pos] == addr) begin
                        ready_at[pos] = '0;
                        pend_miss[pos] = 1'b0;
                        if (miss_cnt != 0) miss_cnt = miss_cnt - 8'd1;
                        found = 1'b1;
                    end
                    pos = pos + 7'd1;
                end
                r.matched = found;
            end
            default: ;
        endcase
        r.occupancy = rob_count[STAT_W-1:0];
        r.outstanding_misses = miss_cnt;
        r.full_res = (rob_count == ROB_DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
            idle_cycles = 0;
        end else begin
            if (offering && s_axis_tready) begin
                status_q.push_back(predict_status(cur_item.kind, cur_item.cls, cur_item.addr));
                offering = 1'b0;
                idle_cycles = 0;
            end
            if (!offering && item_q.size() != 0) begin
                if (idle_cycles >= item_q[0].gap) begin
                    cur_item = item_q.pop_front();
                    s_axis_tuser <= cur_item.kind;
                    s_axis_tdata <= IN_TDATA_W'({cur_item.addr, cur_item.cls});
                    offering = 1'b1;
                end else begin
                    idle_cycles++;
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    // sink side and checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(t_result)-1:0];
                if (status_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata, 0);
                end else begin
                    want = status_q.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                    if (got.committed !== want.committed)
                        report_mismatch("committed", got.committed, want.committed);
                    if (got.matched !== want.matched)
                        report_mismatch("matched", got.matched, want.matched);
                    if (got.occupancy !== want.occupancy)
                        report_mismatch("occupancy", got.occupancy, want.occupancy);
                    if (got.outstanding_misses !== want.outstanding_misses)
                        report_mismatch("outstanding_misses", got.outstanding_misses,
                                        want.outstanding_misses);
                    if (got.full_res !== want.full_res)
                        report_mismatch("full_res", got.full_res, want.full_res);
                end
                beats++;
                // every fourth stretch of 64 beats runs without stalls
                stall_left = ((beats / 64) % 4 == 0) ? 0 : $urandom_range(0, 5);
            end
            if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    task automatic push_item(input logic [KIND_W-1:0] kind, input logic [CLS_W-1:0] cls,
                             input logic [ADDR_W-1:0] addr, input int gap);
        t_rob_item it;
        it.kind = kind;
        it.cls = cls;
        it.addr = addr;
        it.gap = gap;
        item_q.push_back(it);
    endtask

    task automatic refresh_pool();
        miss_pool[0] = '0;
        miss_pool[1] = '1;
        for (int i = 2; i < 8; i++) miss_pool[i] = rand_addr();
    endtask

    function automatic logic [CLS_W-1:0] CLS_CLS_pick();
        return CLS_W'($urandom_range(CLS_NONMEM, CLS_L3));
    endfunction

    task automatic queue_random(input int n, input int issue_pct, input int tick_pct);
        logic [KIND_W-1:0] kind;
        logic [CLS_W-1:0]  cls;
        logic [ADDR_W-1:0] addr;
        int                r;
        int                c;
        int                gap;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            c = $urandom_range(0, 99);
            if (r < issue_pct) kind = KIND_ISSUE;
            else if (r < issue_pct + tick_pct) kind = KIND_TICK;
            else if (r < 98) kind = KIND_COMPL;
            else kind = KIND_NONE;
            if (c < 5) cls = (c < 2) ? CLS_BAD_LO : CLS_BAD_HI;
            else if (c < 35) cls = CLS_MISS;
            else cls = CLS_CLS_pick();
            addr = ($urandom_range(0, 99) < 80) ? miss_pool[$urandom_range(0, 7)] : rand_addr();
            gap = ((k / 40) % 3 == 0) ? 0 : $urandom_range(0, 5);
            push_item(kind, cls, addr, gap);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_NONMEM: lat_nonmem = val[LAT_SHORT_W-1:0];
            CFG_L1:     lat_l1 = val[LAT_SHORT_W-1:0];
            CFG_L2:     lat_l2 = val[LAT_SHORT_W-1:0];
            CFG_L3:     lat_l3 = val[LAT_SHORT_W-1:0];
            CFG_MISS:   lat_miss = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_latencies(input int nm, input int l1, input int l2, input int l3,
                                  input int ms);
        write_reg(CFG_NONMEM, CFG_DATA_W'(nm));
        write_reg(CFG_L1, CFG_DATA_W'(l1));
        write_reg(CFG_L2, CFG_DATA_W'(l2));
        write_reg(CFG_L3, CFG_DATA_W'(l3));
        write_reg(CFG_MISS, CFG_DATA_W'(ms));
    endtask

    // wait until the source has nothing left and every result beat is back
    task automatic settle();
        do @(negedge i_clk);
        while (item_q.size() != 0 || s_axis_tvalid || status_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < ROB_DEPTH; i++) begin
            ready_at[i] = '0;
            pend_addr[i] = '0;
            pend_miss[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty tick, odd kinds and classes, stale address, no match, commits
        push_item(KIND_TICK, CLS_NONMEM, '0, 0);
        push_item(KIND_NONE, CLS_BAD_HI, '1, 1);
        push_item(KIND_ISSUE, CLS_NONMEM, '1, 0);
        push_item(KIND_ISSUE, CLS_WRITE, 48'h5555_5555_5555, 2);
        push_item(KIND_ISSUE, CLS_L1, 48'hAAAA_AAAA_AAAA, 0);
        push_item(KIND_ISSUE, CLS_L2, '0, 0);
        push_item(KIND_ISSUE, CLS_L3, '0, 3);
        push_item(KIND_ISSUE, CLS_MISS, '1, 0);
        push_item(KIND_ISSUE, CLS_MISS, 48'h8000_0000_0001, 0);
        push_item(KIND_ISSUE, CLS_BAD_LO, 48'h8000_0000_0001, 5);
        push_item(KIND_ISSUE, CLS_BAD_HI, '1, 0);
        push_item(KIND_COMPL, CLS_NONMEM, '1, 0);
        push_item(KIND_COMPL, CLS_NONMEM, '1, 1);
        push_item(KIND_COMPL, CLS_NONMEM, '0, 0);
        for (int i = 0; i < 7; i++) push_item(KIND_TICK, CLS_NONMEM, '0, i % 3);
        push_item(KIND_COMPL, CLS_MISS, 48'h8000_0000_0001, 0);
        push_item(KIND_ISSUE, CLS_MISS, 48'h8000_0000_0001, 0);
        push_item(KIND_NONE, CLS_NONMEM, '0, 4);
        settle();

        // zero latencies: full retire width per tick
        load_latencies(0, 0, 0, 0, 0);
        refresh_pool();
        queue_random(200, 55, 30);
        settle();

        // moderate latencies, issue heavy so the buffer fills; sink holds off meanwhile
        load_latencies($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 63), $urandom_range(0, 150));
        refresh_pool();
        queue_random(300, 65, 15);
        repeat (50) @(negedge i_clk);
        hold_req_cnt++;
        settle();

        // upper data bits of the short registers must be dropped, spare index ignored
        write_reg(CFG_SPARE, '1);
        for (int i = 0; i < 4; i++)
            write_reg(CFG_IDX_W'(i), {6'($urandom_range(1, 63)), 10'($urandom_range(0, 40))});
        write_reg(CFG_MISS, CFG_DATA_W'($urandom_range(0, 120)));
        refresh_pool();
        queue_random(200, 45, 35);
        settle();

        // misses that retire unresolved drive the outstanding count into saturation
        load_latencies($urandom_range(0, 3), 0, 1, 2, 0);
        refresh_pool();
        for (int i = 0; i < 40; i++) push_item(KIND_TICK, CLS_NONMEM, '0, 0);
        for (int r = 0; r < 70; r++) begin
            for (int i = 0; i < 4; i++)
                push_item(KIND_ISSUE, CLS_MISS, miss_pool[$urandom_range(0, 7)],
                          (r % 4 == 0) ? $urandom_range(0, 5) : 0);
            push_item(KIND_TICK, CLS_NONMEM, '0, 0);
            push_item(KIND_TICK, CLS_NONMEM, '0, 0);
        end
        settle();

        // top of range latencies
        load_latencies(1023, 1023, 1023, 1023, 65535);
        refresh_pool();
        queue_random(120, 60, 20);
        settle();

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
